// File: hdl/cnpj_pkg.sv
// ----------------------------------------------------------------------------
// cnpj_pkg: shared types and tables for the CNPJ check digit validator
// Request and result payloads, status codes, position and weight tables.
// ----------------------------------------------------------------------------
package cnpj_pkg;

  localparam int unsigned PosW = 5;
  localparam logic [PosW-1:0] POS_MAX  = 5'd31;
  localparam logic [PosW-1:0] POS_LAST = 5'd17;
  localparam logic [PosW-1:0] CNPJ_LEN = 5'd18;

  // digit index code for separator positions
  localparam logic [3:0] DIGIT_NONE = 4'hF;
  localparam logic [3:0] DIGIT_FIRST_CHECK  = 4'd12;
  localparam logic [3:0] DIGIT_SECOND_CHECK = 4'd13;
  localparam logic [3:0] DIGIT_BRANCH_FIRST = 4'd8;
  localparam logic [3:0] DIGIT_BRANCH_LAST  = 4'd11;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LENGTH    = 3'd1,
    ST_REPEAT    = 3'd2,
    ST_BRANCH    = 3'd3,
    ST_CHECK     = 3'd4,
    ST_NON_DIGIT = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_string;
  } cnpj_in_t;

  typedef struct packed {
    logic       is_valid;
    logic [2:0] status;
  } cnpj_out_t;

  // everything the verdict needs, captured on the final character
  typedef struct packed {
    logic       len_ok;
    logic       non_digit;
    logic       differ;
    logic       branch_ok;
    logic [9:0] sum1;
    logic [9:0] sum2;
    logic [3:0] chk1;
    logic [3:0] chk2;
  } cnpj_snap_t;

  function automatic logic [3:0] digit_index(logic [PosW-1:0] pos);
    logic [3:0] d;
    case (pos)
      5'd0:    d = 4'd0;
      5'd1:    d = 4'd1;
      5'd3:    d = 4'd2;
      5'd4:    d = 4'd3;
      5'd5:    d = 4'd4;
      5'd7:    d = 4'd5;
      5'd8:    d = 4'd6;
      5'd9:    d = 4'd7;
      5'd11:   d = 4'd8;
      5'd12:   d = 4'd9;
      5'd13:   d = 4'd10;
      5'd14:   d = 4'd11;
      5'd16:   d = 4'd12;
      5'd17:   d = 4'd13;
      default: d = DIGIT_NONE;
    endcase
    return d;
  endfunction

  // weights 5..2,9..2 for the first sum
  function automatic logic [3:0] weight_one(logic [3:0] d);
    logic [3:0] w;
    case (d)
      4'd0:    w = 4'd5;
      4'd1:    w = 4'd4;
      4'd2:    w = 4'd3;
      4'd3:    w = 4'd2;
      4'd4:    w = 4'd9;
      4'd5:    w = 4'd8;
      4'd6:    w = 4'd7;
      4'd7:    w = 4'd6;
      4'd8:    w = 4'd5;
      4'd9:    w = 4'd4;
      4'd10:   w = 4'd3;
      4'd11:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // weights 6..2,9..3 for the second sum
  function automatic logic [3:0] weight_two(logic [3:0] d);
    logic [3:0] w;
    case (d)
      4'd0:    w = 4'd6;
      4'd1:    w = 4'd5;
      4'd2:    w = 4'd4;
      4'd3:    w = 4'd3;
      4'd4:    w = 4'd2;
      4'd5:    w = 4'd9;
      4'd6:    w = 4'd8;
      4'd7:    w = 4'd7;
      4'd8:    w = 4'd6;
      4'd9:    w = 4'd5;
      4'd10:   w = 4'd4;
      4'd11:   w = 4'd3;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // remainder by 11 via reciprocal: q = (s * 1490) >> 14 is exact for s < 1024
  function automatic logic [3:0] mod_eleven(logic [9:0] s);
    logic [20:0] prod;
    logic [6:0]  q;
    logic [10:0] r;
    prod = 21'(s) * 21'd1490;
    q    = prod[20:14];
    r    = {1'b0, s} - 11'(q) * 11'd11;
    return r[3:0];
  endfunction

  // 11 - r, forced to zero when that reaches 10 or more
  function automatic logic [3:0] check_of_rem(logic [3:0] r);
    logic [3:0] c;
    if (r <= 4'd1) begin
      c = 4'd0;
    end else begin
      c = 4'd11 - r;
    end
    return c;
  endfunction

endpackage

// File: hdl/cnpj_check_digit_validator.sv
// ----------------------------------------------------------------------------
// cnpj_check_digit_validator: streaming CNPJ check digit validation
// Validates an 18-character formatted registration number, one byte a request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one ASCII
//   byte per request, with end_of_string set on the final byte. Separator
//   positions are skipped; digit positions feed two weighted sums.
//   Output channel (out_valid_o / out_ready_i / out_data_o) carries one
//   status per string, raised only for the request that ends the string.
//   Throughput: one byte per cycle, sustained while in_ready_o is high; the
//   running sums take one small multiply and add per byte.
//   Path: the final byte's state is held in the capture register, and the
//   verdict logic, whose remainder-by-11 units are combinational, feeds
//   the output register.
//   Stall: the capture and output registers form a two-deep queue, so bytes
//   keep flowing while a status waits; in_ready_o falls only when both hold
//   an unclaimed status.
//   Reset: clears position, sums and flags and empties both registers.
// ----------------------------------------------------------------------------
module cnpj_check_digit_validator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cnpj_pkg::cnpj_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cnpj_pkg::cnpj_out_t out_data_o
);
  import cnpj_pkg::*;

  logic       accept, fire;
  cnpj_snap_t snap;
  cnpj_snap_t s1_q;
  logic       s1_valid_q, s1_valid_d;
  cnpj_out_t  out_q, verdict;
  logic       out_valid_q, out_valid_d;
  logic       out_free, s1_adv;

  logic [3:0] r1, r2, c1, c2, r2b;
  logic [4:0] t;
  status_e    st;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;

  cnpj_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .data_i   (in_data_i),
    .fire_o   (fire),
    .snap_o   (snap)
  );

  // verdict from the captured state
  always_comb begin
    r1 = mod_eleven(s1_q.sum1);
    r2 = mod_eleven(s1_q.sum2);
    c1 = check_of_rem(r1);
    t  = {1'b0, r2} + {c1, 1'b0};
    if (t >= 5'd22) begin
      r2b = 4'(t - 5'd22);
    end else if (t >= 5'd11) begin
      r2b = 4'(t - 5'd11);
    end else begin
      r2b = t[3:0];
    end
    c2 = check_of_rem(r2b);

    if (!s1_q.len_ok) begin
      st = ST_LENGTH;
    end else if (s1_q.non_digit) begin
      st = ST_NON_DIGIT;
    end else if (!s1_q.differ) begin
      st = ST_REPEAT;
    end else if (!s1_q.branch_ok) begin
      st = ST_BRANCH;
    end else if ((c1 == s1_q.chk1) && (c2 == s1_q.chk2)) begin
      st = ST_OK;
    end else begin
      st = ST_CHECK;
    end
    verdict.is_valid = (st == ST_OK);
    verdict.status   = st;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: load on capture and on advance only
  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_q <= snap;
    end
    if (s1_adv) begin
      out_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_valid_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_valid == (out_data_o.status == ST_OK)))
    else $error("is_valid disagrees with status");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the queue");

  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> s1_valid_q)
    else $error("final byte not captured");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("verdict lost on advance");

endmodule

// File: hdl/cnpj_accum.sv
// ----------------------------------------------------------------------------
// cnpj_accum: per-character accumulation of the CNPJ digit state
// Running weighted sums, repeat and branch tracking, check digit capture.
// ----------------------------------------------------------------------------
module cnpj_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  cnpj_pkg::cnpj_in_t   data_i,
  output logic                 fire_o,
  output cnpj_pkg::cnpj_snap_t snap_o
);
  import cnpj_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [9:0]      sum1_q, sum1_d, sum2_q, sum2_d;
  logic [3:0]      prev_q, prev_d;
  logic            differ_q, differ_d;
  logic            branch_ok_q, branch_ok_d;
  logic [3:0]      chk1_q, chk1_d, chk2_q, chk2_d;
  logic            non_digit_q, non_digit_d;

  logic [9:0] u_sum1, u_sum2;
  logic [3:0] u_prev, u_chk1, u_chk2;
  logic       u_differ, u_branch_ok, u_non_digit;
  logic [3:0] d_idx, v;
  logic [7:0] prod1, prod2;
  logic       is_digit;
  logic       last;

  assign last   = data_i.end_of_string;
  assign fire_o = accept_i && last;

  always_comb begin
    d_idx    = (pos_q < CNPJ_LEN) ? digit_index(pos_q) : DIGIT_NONE;
    is_digit = (data_i.char_byte >= 8'h30) && (data_i.char_byte <= 8'h39);
    v        = is_digit ? data_i.char_byte[3:0] : 4'd0;
    prod1    = {4'b0, v} * {4'b0, weight_one(d_idx)};
    prod2    = {4'b0, v} * {4'b0, weight_two(d_idx)};

    u_sum1      = sum1_q;
    u_sum2      = sum2_q;
    u_prev      = prev_q;
    u_differ    = differ_q;
    u_branch_ok = branch_ok_q;
    u_chk1      = chk1_q;
    u_chk2      = chk2_q;
    u_non_digit = non_digit_q;

    if (d_idx != DIGIT_NONE) begin
      if (!is_digit) begin
        u_non_digit = 1'b1;
      end
      if ((d_idx != 4'd0) && (v != prev_q)) begin
        u_differ = 1'b1;
      end
      u_prev = v;
      // weights are zero for the check digits, so the add is harmless there
      u_sum1 = sum1_q + {2'b0, prod1};
      u_sum2 = sum2_q + {2'b0, prod2};
      if ((d_idx >= DIGIT_BRANCH_FIRST) && (d_idx < DIGIT_BRANCH_LAST) && (v != 4'd0)) begin
        u_branch_ok = 1'b0;
      end
      if ((d_idx == DIGIT_BRANCH_LAST) && (v != 4'd1) && (v != 4'd2)) begin
        u_branch_ok = 1'b0;
      end
      if (d_idx == DIGIT_FIRST_CHECK) begin
        u_chk1 = v;
      end
      if (d_idx == DIGIT_SECOND_CHECK) begin
        u_chk2 = v;
      end
    end

    snap_o.len_ok    = (pos_q == POS_LAST);
    snap_o.non_digit = u_non_digit;
    snap_o.differ    = u_differ;
    snap_o.branch_ok = u_branch_ok;
    snap_o.sum1      = u_sum1;
    snap_o.sum2      = u_sum2;
    snap_o.chk1      = u_chk1;
    snap_o.chk2      = u_chk2;
  end

  always_comb begin
    pos_d       = pos_q;
    sum1_d      = sum1_q;
    sum2_d      = sum2_q;
    prev_d      = prev_q;
    differ_d    = differ_q;
    branch_ok_d = branch_ok_q;
    chk1_d      = chk1_q;
    chk2_d      = chk2_q;
    non_digit_d = non_digit_q;
    if (accept_i) begin
      if (last) begin
        // start afresh for the next string
        pos_d       = '0;
        sum1_d      = '0;
        sum2_d      = '0;
        prev_d      = '0;
        differ_d    = 1'b0;
        branch_ok_d = 1'b1;
        chk1_d      = '0;
        chk2_d      = '0;
        non_digit_d = 1'b0;
      end else begin
        pos_d       = (pos_q < POS_MAX) ? pos_q + 5'd1 : POS_MAX;
        sum1_d      = u_sum1;
        sum2_d      = u_sum2;
        prev_d      = u_prev;
        differ_d    = u_differ;
        branch_ok_d = u_branch_ok;
        chk1_d      = u_chk1;
        chk2_d      = u_chk2;
        non_digit_d = u_non_digit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum1_q      <= '0;
      sum2_q      <= '0;
      prev_q      <= '0;
      differ_q    <= 1'b0;
      branch_ok_q <= 1'b1;
      chk1_q      <= '0;
      chk2_q      <= '0;
      non_digit_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum1_q      <= sum1_d;
      sum2_q      <= sum2_d;
      prev_q      <= prev_d;
      differ_q    <= differ_d;
      branch_ok_q <= branch_ok_d;
      chk1_q      <= chk1_d;
      chk2_q      <= chk2_d;
      non_digit_q <= non_digit_d;
    end
  end

endmodule

// File: tb/sv/cnpj_check_digit_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnpj_check_digit_validator_tb: self-checking bench for the CNPJ validator
// Streams formatted registration numbers, well-formed and broken, through the
// request channel under varying idle and stall patterns. Each status is
// compared against an in-bench model of the checksum and rule logic.
// ----------------------------------------------------------------------------
module cnpj_check_digit_validator_tb;
  import cnpj_pkg::*;

  localparam int unsigned STR_CHARS   = 18;
  localparam int unsigned MOD_BASE    = 11;
  localparam int unsigned PHASE_CHARS = 330;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_TAIL  = 6;
  // digit index per character position, -1 for separators
  localparam int DIGIT_SLOT [STR_CHARS] = '{0, 1, -1, 2, 3, 4, -1, 5, 6, 7, -1,
                                            8, 9, 10, 11, -1, 12, 13};
  localparam int SEND_IDLE  [4] = '{0, 51, 0, 38};
  localparam int RECV_STALL [4] = '{0, 0, 51, 38};

  typedef enum int {
    K_VALID, K_BAD_CHECK, K_BAD_BRANCH, K_REPEAT, K_NON_DIGIT, K_SHORT, K_LONG, K_NOISE
  } shape_e;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  cnpj_in_t   in_data_i   = '0;
  cnpj_out_t  out_data_o;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned chars_sent;
  int unsigned strings_sent;
  int unsigned quiet_cycles;
  bit          took;
  int unsigned dg [14];
  logic [7:0]  text_q [$];

  function automatic int unsigned weight_a(int unsigned slot);
    return (slot < 4) ? 5 - slot : 13 - slot;
  endfunction

  function automatic int unsigned weight_b(int unsigned slot);
    return (slot < 5) ? 6 - slot : 14 - slot;
  endfunction

  function automatic int unsigned check_digit_of(int unsigned s);
    int unsigned c;
    c = MOD_BASE - (s % MOD_BASE);
    return (c >= 10) ? 0 : c;
  endfunction

  class cnpj_verdict_board;
    logic [4:0] char_pos;
    logic [9:0] sum_a;
    logic [9:0] sum_b;
    logic [3:0] last_digit;
    logic       seen_change;
    logic       branch_good;
    logic [3:0] got_check_a;
    logic [3:0] got_check_b;
    logic       bad_char;
    cnpj_out_t  verdicts_due [$];
    int unsigned mismatches;
    int unsigned tally [8];

    function new();
      mismatches = 0;
      foreach (tally[i]) tally[i] = 0;
      clear_string();
    endfunction

    function void clear_string();
      char_pos    = '0;
      sum_a       = '0;
      sum_b       = '0;
      last_digit  = '0;
      seen_change = 1'b0;
      branch_good = 1'b1;
      got_check_a = '0;
      got_check_b = '0;
      bad_char    = 1'b0;
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction

    function void take_char(cnpj_in_t r);
      logic [4:0]  at;
      int          slot;
      logic [3:0]  v;
      int unsigned c1;
      int unsigned c2;
      status_e     st;
      cnpj_out_t   want;
      at = char_pos;
      if (at < STR_CHARS) begin
        slot = DIGIT_SLOT[at];
        if (slot >= 0) begin
          v = 4'd0;
          if (r.char_byte >= 8'h30 && r.char_byte <= 8'h39) begin
            v = r.char_byte[3:0];
          end else begin
            bad_char = 1'b1;
          end
          if (slot > 0 && v != last_digit) seen_change = 1'b1;
          last_digit = v;
          if (slot < 12) begin
            sum_a = sum_a + 10'(v * weight_a(slot));
            sum_b = sum_b + 10'(v * weight_b(slot));
          end
          if (slot >= 8 && slot <= 10 && v != 4'd0) branch_good = 1'b0;
          if (slot == 11 && v != 4'd1 && v != 4'd2) branch_good = 1'b0;
          if (slot == 12) got_check_a = v;
          if (slot == 13) got_check_b = v;
        end
      end
      char_pos = (at < POS_MAX) ? at + 5'd1 : POS_MAX;
      if (r.end_of_string) begin
        if (at != POS_LAST) begin
          st = ST_LENGTH;
        end else if (bad_char) begin
          st = ST_NON_DIGIT;
        end else if (!seen_change) begin
          st = ST_REPEAT;
        end else if (!branch_good) begin
          st = ST_BRANCH;
        end else begin
          c1 = check_digit_of(sum_a);
          c2 = check_digit_of(sum_b + 2 * c1);
          st = (c1 == got_check_a && c2 == got_check_b) ? ST_OK : ST_CHECK;
        end
        want.is_valid = (st == ST_OK);
        want.status   = st;
        verdicts_due.insert(verdicts_due.size(), want);
        clear_string();
      end
    endfunction

    function void check_verdict(cnpj_out_t got);
      cnpj_out_t want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected status, expected none, actual is_valid=%0b status=%0d",
                 $time, got.is_valid, got.status);
        return;
      end
      want = verdicts_due.pop_front();
      tally[want.status]++;
      if (got.is_valid !== want.is_valid) begin
        mismatches++;
        $display("%0t: is_valid mismatch, expected %0b, actual %0b",
                 $time, want.is_valid, got.is_valid);
      end
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
    endfunction
  endclass

  cnpj_verdict_board board;

  cnpj_check_digit_validator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // sample both channels and guard against a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      took = 1'b0;
      if (in_valid_i && in_ready_o) begin
        board.take_char(in_data_i);
        took = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        board.check_verdict(out_data_o);
        took = 1'b1;
      end
      quiet_cycles = took ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{char_byte: ch, end_of_string: last};
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    strings_sent++;
  endtask

  task automatic seal_checks();
    int unsigned s1;
    int unsigned s2;
    s1 = 0;
    s2 = 0;
    for (int k = 0; k < 12; k++) begin
      s1 += dg[k] * weight_a(k);
      s2 += dg[k] * weight_b(k);
    end
    dg[12] = check_digit_of(s1);
    dg[13] = check_digit_of(s2 + 2 * dg[12]);
  endtask

  task automatic build_number(input shape_e shape);
    int unsigned n;
    int          at;
    logic [7:0]  junk;
    for (int k = 0; k < 8; k++) dg[k] = $urandom_range(9);
    for (int k = 8; k < 11; k++) dg[k] = 0;
    dg[11] = $urandom_range(2, 1);
    if (shape == K_BAD_BRANCH) begin
      for (int k = 8; k < 12; k++) dg[k] = $urandom_range(9);
    end
    if (shape == K_REPEAT) begin
      n = $urandom_range(9);
      for (int k = 0; k < 12; k++) dg[k] = n;
    end
    seal_checks();
    if (shape == K_REPEAT) begin
      dg[12] = n;
      dg[13] = n;
    end
    if (shape == K_BAD_CHECK) begin
      n = $urandom_range(13, 12);
      dg[n] = (dg[n] + $urandom_range(9, 1)) % 10;
    end
    text_q.delete();
    for (int p = 0; p < STR_CHARS; p++) begin
      if (DIGIT_SLOT[p] >= 0) begin
        text_q.insert(text_q.size(), 8'h30 + 8'(dg[DIGIT_SLOT[p]]));
      end else if ($urandom_range(9) == 0) begin
        text_q.insert(text_q.size(), 8'($urandom_range(255)));
      end else begin
        text_q.insert(text_q.size(), (p == 10) ? "/" : (p == 15) ? "-" : ".");
      end
    end
    case (shape)
      K_NON_DIGIT: begin
        do at = $urandom_range(STR_CHARS - 1); while (DIGIT_SLOT[at] < 0);
        do junk = 8'($urandom_range(255)); while (junk >= "0" && junk <= "9");
        text_q[at] = junk;
      end
      K_SHORT: begin
        n = $urandom_range(STR_CHARS - 1, 1);
        while (text_q.size() > n) void'(text_q.pop_back());
      end
      K_LONG: begin
        n = $urandom_range(40, STR_CHARS + 1);
        while (text_q.size() < n) text_q.insert(text_q.size(), 8'($urandom_range(255)));
      end
      K_NOISE: begin
        foreach (text_q[i]) text_q[i] = 8'($urandom_range(255));
      end
      default: ;
    endcase
  endtask

  function automatic shape_e pick_shape();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return K_VALID;
    if (r < 65) return K_BAD_CHECK;
    if (r < 73) return K_BAD_BRANCH;
    if (r < 78) return K_REPEAT;
    if (r < 86) return K_NON_DIGIT;
    if (r < 93) return K_SHORT;
    if (r < 98) return K_LONG;
    return K_NOISE;
  endfunction

  // hold requests until every status is back, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic run_directed();
    build_number(K_VALID);
    send_text();
    // separators at both byte extremes
    build_number(K_VALID);
    text_q[2]  = 8'h00;
    text_q[6]  = 8'hFF;
    text_q[10] = 8'h00;
    text_q[15] = 8'hFF;
    send_text();
    build_number(K_REPEAT);
    send_text();
    build_number(K_BAD_BRANCH);
    text_q[14] = "3";
    send_text();
    build_number(K_BAD_CHECK);
    send_text();
    // characters just outside the digit range
    build_number(K_VALID);
    text_q[0] = 8'h2F;
    send_text();
    build_number(K_VALID);
    text_q[17] = 8'h3A;
    send_text();
    send_byte("1", 1'b1);
    strings_sent++;
    build_number(K_LONG);
    while (text_q.size() < 40) text_q.insert(text_q.size(), 8'($urandom_range(255)));
    send_text();
  endtask

  initial begin
    board        = new();
    chars_sent   = 0;
    strings_sent = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = SEND_IDLE[ph];
      stall_pct = RECV_STALL[ph];
      if (ph == 0) run_directed();
      while (chars_sent < (ph + 1) * PHASE_CHARS) begin
        build_number(pick_shape());
        send_text();
      end
      drain();
    end
    $display("sent %0d characters in %0d strings across four idle/stall mixes",
             chars_sent, strings_sent);
    $display("statuses seen: ok %0d, length %0d, repeat %0d, branch %0d, check %0d, non-digit %0d",
             board.tally[ST_OK], board.tally[ST_LENGTH], board.tally[ST_REPEAT],
             board.tally[ST_BRANCH], board.tally[ST_CHECK], board.tally[ST_NON_DIGIT]);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/cnpj_pkg.sv
hdl/cnpj_accum.sv
hdl/cnpj_check_digit_validator.sv
tb/sv/cnpj_check_digit_validator_tb.sv
